// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL files of the serial message ring buffers.
// Both macros sample on clk and are held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define SMR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// when ante holds, cons must hold in the same cycle
`define SMR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/smr_pkg.sv -----
// Shared types, constants and command/status structs of the serial message ring buffers.
// No dependencies; used by smr_ctrl, smr_dp and the top level.
package smr_pkg;

    localparam int RING_DEPTH = 16;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = 4;
    localparam int MAX_READ   = 15;
    localparam int MSG_MAX    = 15;

    localparam logic [7:0] TERM_RESET = 8'd36;   // '$'

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [7:0]       byte_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // output word select
    localparam logic [2:0] OUT_REFUSE   = 3'd0;
    localparam logic [2:0] OUT_ACK      = 3'd1;
    localparam logic [2:0] OUT_LINE_IN  = 3'd2;
    localparam logic [2:0] OUT_LINE_RAM = 3'd3;
    localparam logic [2:0] OUT_MSG      = 3'd4;

    typedef struct packed {
        logic       in_load;
        logic       rx_push;
        logic       tx_push;
        logic       tx_direct;
        logic       tx_rd;
        logic       busy_clr;
        logic       scan_start;
        logic       scan_rd;
        logic       scan_end;
        logic       scan_dec;
        logic       emit_rd;
        logic       emit_step;
        logic       out_load;
        logic [2:0] out_sel;
    } cmd_t;

    typedef struct packed {
        logic rx_full;
        logic rx_empty;
        logic tx_full;
        logic tx_empty;
        logic busy;
        logic pend_zero;
        logic out_free;
        logic scan_stop;
        logic scan_limit;
        logic emit_last;
    } sts_t;

    function automatic ptr_t ptr_adv(ptr_t p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

// ----- design/smr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/smr_dp.sv -----
// Datapath: both rings, pointers, message count, transmitter flag, scan logic, output register.
// Depends on smr_pkg and smr_ram.
module smr_dp
    import smr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    output sts_t  sts,
    input  byte_t in_data,
    input  logic  cfg_valid,
    input  byte_t cfg_data,
    output logic  m_tvalid,
    input  logic  m_tready,
    output byte_t out_data,
    output logic  out_acc,
    output logic  out_send,
    output logic  out_last,
    output cnt_t  out_count,
    output logic  out_busy
);

    byte_t data_reg;
    byte_t term_reg;
    ptr_t  rx_wptr_reg, rx_wptr_next;
    ptr_t  rx_rptr_reg, rx_rptr_next;
    ptr_t  scan_ptr_reg, scan_ptr_next;
    cnt_t  scan_cnt_reg, scan_cnt_next;
    cnt_t  rem_reg, rem_next;
    ptr_t  tx_wptr_reg, tx_wptr_next;
    ptr_t  tx_rptr_reg, tx_rptr_next;
    logic  busy_reg, busy_next;
    cnt_t  pend_reg, pend_next;
    logic  oval_reg, oval_next;
    byte_t rx_rdata, tx_rdata;
    ptr_t  rx_raddr;

    assign rx_raddr = cmd.scan_rd ? scan_ptr_reg : rx_rptr_reg;

    smr_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ram (
        .clk     (clk),
        .wr_en   (cmd.rx_push),
        .wr_addr (rx_wptr_reg),
        .wr_data (data_reg),
        .rd_en   (cmd.scan_rd | cmd.emit_rd),
        .rd_addr (rx_raddr),
        .rd_data (rx_rdata)
    );

    smr_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ram (
        .clk     (clk),
        .wr_en   (cmd.tx_push),
        .wr_addr (tx_wptr_reg),
        .wr_data (data_reg),
        .rd_en   (cmd.tx_rd),
        .rd_addr (tx_rptr_reg),
        .rd_data (tx_rdata)
    );

    always_comb
    begin
        sts.rx_full    = (ptr_adv(rx_wptr_reg) == rx_rptr_reg);
        sts.rx_empty   = (rx_wptr_reg == rx_rptr_reg);
        sts.tx_full    = (ptr_adv(tx_wptr_reg) == tx_rptr_reg);
        sts.tx_empty   = (tx_wptr_reg == tx_rptr_reg);
        sts.busy       = busy_reg;
        sts.pend_zero  = (pend_reg == '0);
        sts.out_free   = !oval_reg || m_tready;
        sts.scan_stop  = (rx_rdata == term_reg) || (scan_ptr_reg == rx_wptr_reg);
        sts.scan_limit = (scan_cnt_reg >= CNT_W'(MAX_READ));
        sts.emit_last  = (rem_reg == CNT_W'(1));
    end

    always_comb
    begin
        rx_wptr_next  = rx_wptr_reg;
        rx_rptr_next  = rx_rptr_reg;
        scan_ptr_next = scan_ptr_reg;
        scan_cnt_next = scan_cnt_reg;
        rem_next      = rem_reg;
        tx_wptr_next  = tx_wptr_reg;
        tx_rptr_next  = tx_rptr_reg;
        busy_next     = busy_reg;
        pend_next     = pend_reg;
        oval_next     = oval_reg && !m_tready;

        if (cmd.rx_push)
        begin
            rx_wptr_next = ptr_adv(rx_wptr_reg);
            if (data_reg == term_reg && pend_reg != CNT_W'(MSG_MAX))
            begin
                pend_next = pend_reg + 1'b1;
            end
        end
        if (cmd.tx_push)
        begin
            tx_wptr_next = ptr_adv(tx_wptr_reg);
        end
        // idle transmitter: the pushed byte goes straight to the line; a tick's ring read also advances
        if (cmd.tx_direct || cmd.tx_rd)
        begin
            tx_rptr_next = ptr_adv(tx_rptr_reg);
        end
        if (cmd.tx_direct)
        begin
            busy_next = 1'b1;
        end
        if (cmd.busy_clr)
        begin
            busy_next = 1'b0;
        end
        if (cmd.scan_start)
        begin
            scan_ptr_next = rx_rptr_reg;
            scan_cnt_next = '0;
        end
        if (cmd.scan_rd)
        begin
            scan_ptr_next = ptr_adv(scan_ptr_reg);
            scan_cnt_next = scan_cnt_reg + 1'b1;
        end
        if (cmd.scan_end)
        begin
            rem_next = scan_cnt_reg;
            if (cmd.scan_dec && pend_reg != '0)
            begin
                pend_next = pend_reg - 1'b1;
            end
        end
        if (cmd.emit_rd)
        begin
            rx_rptr_next = ptr_adv(rx_rptr_reg);
        end
        if (cmd.emit_step)
        begin
            rem_next = rem_reg - 1'b1;
        end
        if (cmd.out_load)
        begin
            oval_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg     <= TERM_RESET;
            rx_wptr_reg  <= '0;
            rx_rptr_reg  <= '0;
            scan_ptr_reg <= '0;
            scan_cnt_reg <= '0;
            rem_reg      <= '0;
            tx_wptr_reg  <= '0;
            tx_rptr_reg  <= '0;
            busy_reg     <= 1'b0;
            pend_reg     <= '0;
            oval_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                term_reg <= cfg_data;
            end
            rx_wptr_reg  <= rx_wptr_next;
            rx_rptr_reg  <= rx_rptr_next;
            scan_ptr_reg <= scan_ptr_next;
            scan_cnt_reg <= scan_cnt_next;
            rem_reg      <= rem_next;
            tx_wptr_reg  <= tx_wptr_next;
            tx_rptr_reg  <= tx_rptr_next;
            busy_reg     <= busy_next;
            pend_reg     <= pend_next;
            oval_reg     <= oval_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            data_reg <= in_data;
        end
        if (cmd.out_load)
        begin
            out_count <= pend_next;
            out_busy  <= busy_next;
            case (cmd.out_sel)
                OUT_ACK:
                begin
                    out_data <= '0;
                    out_acc  <= 1'b1;
                    out_send <= 1'b0;
                    out_last <= 1'b1;
                end
                OUT_LINE_IN:
                begin
                    out_data <= data_reg;
                    out_acc  <= 1'b1;
                    out_send <= 1'b1;
                    out_last <= 1'b1;
                end
                OUT_LINE_RAM:
                begin
                    out_data <= tx_rdata;
                    out_acc  <= 1'b1;
                    out_send <= 1'b1;
                    out_last <= 1'b1;
                end
                OUT_MSG:
                begin
                    out_data <= rx_rdata;
                    out_acc  <= 1'b1;
                    out_send <= 1'b0;
                    out_last <= sts.emit_last;
                end
                default:
                begin
                    out_data <= '0;
                    out_acc  <= 1'b0;
                    out_send <= 1'b0;
                    out_last <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid = oval_reg;

endmodule

// ----- design/smr_ctrl.sv -----
// Controller: accepts input words, sequences ring updates, message scan and message emit.
// Depends on smr_pkg.
module smr_ctrl
    import smr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] s_mode,
    input  sts_t       sts,
    output cmd_t       cmd
);

    localparam logic [1:0] MODE_RX   = 2'd0;
    localparam logic [1:0] MODE_TXQ  = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;
    localparam logic [1:0] MODE_READ = 2'd3;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXEC   = 3'd1;
    localparam logic [2:0] ST_TX_OUT = 3'd2;
    localparam logic [2:0] ST_SCAN_A = 3'd3;
    localparam logic [2:0] ST_SCAN_B = 3'd4;
    localparam logic [2:0] ST_EMIT_A = 3'd5;
    localparam logic [2:0] ST_EMIT_B = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd        = '0;
        cmd.out_sel = OUT_REFUSE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.in_load = 1'b1;
                    mode_next   = s_mode;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (mode_reg)
                    MODE_RX:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                            if (!sts.rx_full)
                            begin
                                cmd.rx_push = 1'b1;
                                cmd.out_sel = OUT_ACK;
                            end
                        end
                    end
                    MODE_TXQ:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                            if (!sts.tx_full)
                            begin
                                cmd.tx_push = 1'b1;
                                if (!sts.busy)
                                begin
                                    cmd.tx_direct = 1'b1;
                                    cmd.out_sel   = OUT_LINE_IN;
                                end
                                else
                                begin
                                    cmd.out_sel = OUT_ACK;
                                end
                            end
                        end
                    end
                    MODE_TICK:
                    begin
                        if (!sts.tx_empty)
                        begin
                            cmd.tx_rd  = 1'b1;
                            state_next = ST_TX_OUT;
                        end
                        else if (sts.out_free)
                        begin
                            cmd.busy_clr = 1'b1;
                            cmd.out_load = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    MODE_READ:
                    begin
                        if (sts.pend_zero || sts.rx_empty)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.out_load = 1'b1;
                                state_next   = ST_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN_A;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_TX_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_LINE_RAM;
                    state_next   = ST_IDLE;
                end
            end
            ST_SCAN_A:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_B;
            end
            ST_SCAN_B:
            begin
                // terminator or ring end lowers the count; the length cap does not
                if (sts.scan_stop)
                begin
                    cmd.scan_end = 1'b1;
                    cmd.scan_dec = 1'b1;
                    state_next   = ST_EMIT_A;
                end
                else if (sts.scan_limit)
                begin
                    cmd.scan_end = 1'b1;
                    state_next   = ST_EMIT_A;
                end
                else
                begin
                    state_next = ST_SCAN_A;
                end
            end
            ST_EMIT_A:
            begin
                cmd.emit_rd = 1'b1;
                state_next  = ST_EMIT_B;
            end
            ST_EMIT_B:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = OUT_MSG;
                    cmd.emit_step = 1'b1;
                    state_next    = sts.emit_last ? ST_IDLE : ST_EMIT_A;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_RX;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

// ----- design/serial_message_ring_buffers.sv -----
// Serial message ring buffers: a receive ring and a transmit ring of RING_DEPTH bytes each
// (one slot always free) between a serial port and a host. Each input word carries a mode in
// s_tuser: line byte received, host byte queued, transmit-done tick, or message read. Modes 0-2
// return exactly one result word; a message read returns one word per byte up to and including
// the terminator, ring end or MAX_READ cap (m_tlast on the final one), or a single refused word.
// Every result reports the message count and transmitter busy flag as they stand after the input
// is handled. Timing: one input is handled at a time. Byte and empty-tick inputs are accepted,
// then executed; a tick that sends a queued byte adds a step, as the transmit ring is read through
// the registered read port of its RAM. A message read walks the message twice through the receive
// RAM's single read port, once to find its length and whether the count drops, once to emit
// the bytes. Output back-pressure can stall any result load. The terminator register resets to
// '$'; the user writes it through cfg_valid/cfg_data only while the block is idle, which the
// block does not enforce. Depends on smr_pkg, smr_ctrl, smr_dp, smr_ram and assert_macros.svh.
`include "assert_macros.svh"

module serial_message_ring_buffers
    import smr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_in
    input  logic [1:0]  s_tuser,    // [1:0] mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_out, [11:8] message_count, [12] tx_busy, rest 0
    output logic [1:0]  m_tuser,    // [0] accepted, [1] line_send
    output logic        m_tlast,
    // terminator register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);

    cmd_t  cmd;
    sts_t  sts;
    byte_t out_data;
    logic  out_acc;
    logic  out_send;
    cnt_t  out_count;
    logic  out_busy;

    assign cfg_ready = 1'b1;

    smr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_mode   (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    smr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_data  (out_data),
        .out_acc   (out_acc),
        .out_send  (out_send),
        .out_last  (m_tlast),
        .out_count (out_count),
        .out_busy  (out_busy)
    );

    assign m_tdata = {3'b000, out_busy, out_count, out_data};
    assign m_tuser = {out_send, out_acc};

    // an idle transmitter never leaves bytes queued
    `SMR_ASSERT_IMP(a_idle_tx_empty, !sts.busy, sts.tx_empty, "transmitter idle with bytes queued")
    // a byte for the line is always an accepted result
    `SMR_ASSERT_IMP(a_send_accepted, m_tvalid && m_tuser[1], m_tuser[0], "line byte not accepted")
    // output is loaded only when the register can take it
    `SMR_ASSERT_IMP(a_no_overwrite, cmd.out_load, sts.out_free, "result register overwritten")

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for serial_message_ring_buffers: directed table, then random phases.
// Predicts every result word from its own copy of both rings; depends on smr_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import smr_pkg::*;

    typedef enum logic [1:0] {LINE_RX, HOST_TX, TX_DONE, MSG_READ} mode_e;
    typedef enum logic {ROW_WORD, ROW_TERM} row_kind_e;

    // one result word; field order only matters for the typed table entries
    typedef struct packed {
        byte_t data;
        logic  acc;
        logic  send;
        logic  last;
        cnt_t  count;
        logic  busy;
    } ring_word_t;

    typedef struct {
        row_kind_e  kind;
        mode_e      mode;
        byte_t      value;     // input byte, or new terminator for ROW_TERM
        bit         typed;
        ring_word_t want;
    } script_row_t;

    // no word moved for this long means the block hung; worst honest gap is a receiver
    // stall burst plus a ring walk, or the idle wait before a write
    localparam int QUIET_LIMIT = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] data_in
    logic [1:0]  s_tuser = '0;     // [1:0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] data_out, [11:8] message_count, [12] tx_busy
    logic [1:0]  m_tuser;          // [0] accepted, [1] line_send
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;

    serial_message_ring_buffers u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: head = read side, tail = write side
    byte_t rx_ring [RING_DEPTH];
    byte_t tx_ring [RING_DEPTH];
    ptr_t  rx_head = '0, rx_tail = '0, tx_head = '0, tx_tail = '0;
    logic  tx_live = 1'b0;
    cnt_t  msgs_waiting = '0;
    byte_t term_now = TERM_RESET;

    ring_word_t fresh_words [$];
    ring_word_t awaited_words [$];
    int         errors = 0;
    int         words_sent = 0;
    int         gap_pct = 0;
    int         stall_pct = 0;
    int         stall_left = 0;
    int         quiet = 0;

    // directed table: typed rows are plain refusals, acks and the one-byte direct send
    script_row_t script [0:24] = '{
        '{ROW_WORD, MSG_READ, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0}},
        '{ROW_WORD, TX_DONE,  8'hC3, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0}},
        '{ROW_WORD, LINE_RX,  8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd0, 1'b0}},
        '{ROW_WORD, LINE_RX,  8'hFF, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd0, 1'b0}},
        '{ROW_WORD, LINE_RX,  8'h24, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd1, 1'b0}},
        '{ROW_WORD, MSG_READ, 8'h5C, 1'b0, 16'h0},
        '{ROW_WORD, MSG_READ, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0}},
        '{ROW_WORD, HOST_TX,  8'hA5, 1'b1, {8'hA5, 1'b1, 1'b1, 1'b1, 4'd0, 1'b1}},
        '{ROW_WORD, HOST_TX,  8'h5A, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd0, 1'b1}},
        '{ROW_WORD, TX_DONE,  8'h00, 1'b0, 16'h0},
        '{ROW_WORD, TX_DONE,  8'hFF, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0}},
        '{ROW_WORD, LINE_RX,  8'h41, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd0, 1'b0}},
        '{ROW_WORD, LINE_RX,  8'h24, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd1, 1'b0}},
        '{ROW_TERM, LINE_RX,  8'h00, 1'b0, 16'h0},
        // pending message but no terminator left: read runs the ring empty
        '{ROW_WORD, MSG_READ, 8'h00, 1'b0, 16'h0},
        '{ROW_WORD, LINE_RX,  8'h00, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd1, 1'b0}},
        '{ROW_WORD, MSG_READ, 8'h00, 1'b0, 16'h0},
        '{ROW_TERM, LINE_RX,  8'hFF, 1'b0, 16'h0},
        '{ROW_WORD, LINE_RX,  8'hFF, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd1, 1'b0}},
        '{ROW_WORD, LINE_RX,  8'h7E, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd1, 1'b0}},
        '{ROW_WORD, MSG_READ, 8'h00, 1'b0, 16'h0},
        // bytes left in the ring but no message pending
        '{ROW_WORD, MSG_READ, 8'h00, 1'b1, {8'h00, 1'b0, 1'b0, 1'b1, 4'd0, 1'b0}},
        '{ROW_TERM, LINE_RX,  8'h24, 1'b0, 16'h0},
        '{ROW_WORD, LINE_RX,  8'h24, 1'b1, {8'h00, 1'b1, 1'b0, 1'b1, 4'd1, 1'b0}},
        '{ROW_WORD, MSG_READ, 8'h00, 1'b0, 16'h0}
    };

    function automatic ptr_t next_slot(ptr_t p);
        return ptr_t'((int'(p) + 1) % RING_DEPTH);
    endfunction

    // fills fresh_words with the result words one input causes, updating the rings
    function automatic void forecast_words(mode_e m, byte_t d);
        ring_word_t w;
        byte_t      c;
        int         n;
        bit         done;
        fresh_words.delete();
        w = '0;
        case (m)
            LINE_RX:
                if (next_slot(rx_tail) != rx_head)
                begin
                    rx_ring[rx_tail] = d;
                    rx_tail = next_slot(rx_tail);
                    if (d == term_now && msgs_waiting < MSG_MAX)
                        msgs_waiting++;
                    w.acc = 1'b1;
                end
            HOST_TX:
                if (next_slot(tx_tail) != tx_head)
                begin
                    tx_ring[tx_tail] = d;
                    tx_tail = next_slot(tx_tail);
                    w.acc = 1'b1;
                    if (!tx_live)
                    begin
                        tx_live = 1'b1;
                        w.data = tx_ring[tx_head];
                        w.send = 1'b1;
                        tx_head = next_slot(tx_head);
                    end
                end
            TX_DONE:
                if (tx_head != tx_tail)
                begin
                    w.data = tx_ring[tx_head];
                    w.acc  = 1'b1;
                    w.send = 1'b1;
                    tx_head = next_slot(tx_head);
                end
                else
                    tx_live = 1'b0;
            MSG_READ:
                if (msgs_waiting != 0 && rx_head != rx_tail)
                begin
                    n = 0;
                    done = 1'b0;
                    while (!done)
                    begin
                        c = rx_ring[rx_head];
                        rx_head = next_slot(rx_head);
                        if (c == term_now || rx_head == rx_tail)
                        begin
                            if (msgs_waiting != 0)
                                msgs_waiting--;
                            done = 1'b1;
                        end
                        else if (n + 1 >= MAX_READ)
                            done = 1'b1;
                        w.data = c;
                        w.acc  = 1'b1;
                        w.last = done;
                        fresh_words.push_back(w);
                        n++;
                    end
                end
            default: ;
        endcase
        if (fresh_words.size() == 0)
        begin
            w.last = 1'b1;
            fresh_words.push_back(w);
        end
        // every word of one input reports count and busy as they stand afterwards
        foreach (fresh_words[k])
        begin
            fresh_words[k].count = msgs_waiting;
            fresh_words[k].busy  = tx_live;
        end
    endfunction

    // optional random hold-off, then present one word and wait for the handshake
    task automatic send_word(mode_e m, byte_t d, bit typed, ring_word_t want);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        forecast_words(m, d);
        if (typed)
            awaited_words.push_back(want);
        else
            foreach (fresh_words[k])
                awaited_words.push_back(fresh_words[k]);
        words_sent++;
    endtask

    // terminator changes only once the block has drained and settled
    task automatic write_terminator(byte_t v);
        s_tvalid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        term_now = v;
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // receiver: random stall bursts on m_tready
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rst_n && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
        begin
            stall_left <= $urandom_range(0, 18);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        ring_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_words.size() == 0)
            begin
                $display("%0t: unexpected word, actual tdata %04h tuser %0h tlast %0b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end
            else
            begin
                want = awaited_words.pop_front();
                check_field("data_out",      want.data,  m_tdata[7:0]);
                check_field("message_count", want.count, m_tdata[11:8]);
                check_field("tx_busy",       want.busy,  m_tdata[12]);
                check_field("accepted",      want.acc,   m_tuser[0]);
                check_field("line_send",     want.send,  m_tuser[1]);
                check_field("last",          want.last,  m_tlast);
            end
        end
    end

    // watchdog on cycles where nothing moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        int    gap_mix   [6] = '{0, 15, 30, 10, 25, 0};
        int    stall_mix [6] = '{6, 0, 12, 3, 8, 0};
        byte_t phase_term [6] = '{8'h0A, 8'h00, 8'hFF, 8'h00, 8'h00, TERM_RESET};
        byte_t b;
        byte_t t;
        int    target;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 10;
        stall_pct = 5;
        foreach (script[i])
        begin
            if (script[i].kind == ROW_TERM)
                write_terminator(script[i].value);
            else
                send_word(script[i].mode, script[i].value, script[i].typed, script[i].want);
        end

        // random phases, each under its own terminator and idling mix;
        // the last one runs with no idling at all
        for (int ph = 0; ph < 6; ph++)
        begin
            t = (ph == 3 || ph == 4) ? byte_t'($urandom) : phase_term[ph];
            write_terminator(t);
            gap_pct   = gap_mix[ph];
            stall_pct = stall_mix[ph];
            target    = words_sent + 65;
            while (words_sent < target)
            begin
                case ($urandom_range(0, 15)) inside
                    [0:4]:
                    begin
                        // message: body free of the terminator, then the terminator
                        repeat ($urandom_range(0, 6))
                        begin
                            b = byte_t'($urandom);
                            if (b == term_now)
                                b = b ^ 8'h01;
                            send_word(LINE_RX, b, 1'b0, '0);
                        end
                        send_word(LINE_RX, term_now, 1'b0, '0);
                    end
                    [5:7]:
                        send_word(MSG_READ, byte_t'($urandom), 1'b0, '0);
                    [8:9]:
                        repeat ($urandom_range(1, 8))
                            send_word(HOST_TX, byte_t'($urandom), 1'b0, '0);
                    [10:11]:
                        repeat ($urandom_range(1, 4))
                            send_word(TX_DONE, byte_t'($urandom), 1'b0, '0);
                    [12:13]:
                        send_word(mode_e'($urandom_range(0, 3)), byte_t'($urandom), 1'b0, '0);
                    14:
                        // terminator flood: full ring, count at its ceiling, drops
                        repeat ($urandom_range(4, 10))
                            send_word(LINE_RX, term_now, 1'b0, '0);
                    default:
                        repeat ($urandom_range(2, 4))
                            send_word(MSG_READ, 8'h00, 1'b0, '0);
                endcase
            end
        end

        s_tvalid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/smr_pkg.sv
design/smr_ram.sv
design/smr_dp.sv
design/smr_ctrl.sv
design/serial_message_ring_buffers.sv
tb/sv/testbench.sv
